// File: hw/rtl/dhtrc_pkg.sv
`default_nettype none
package dhtrc_pkg;

  localparam int CacheEntriesDflt = 32;
  localparam logic [15:0] ValidityReset = 16'd2000;

  typedef enum logic [1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_REPLY   = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_INVALID = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ACT_FORWARD   = 3'd0,
    ACT_REPLY     = 3'd1,
    ACT_CACHE_UPD = 3'd2,
    ACT_SELF      = 3'd3,
    ACT_SUCC      = 3'd4,
    ACT_CACHE_HIT = 3'd5,
    ACT_UNKNOWN   = 3'd6,
    ACT_INVALID   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    CFG_PRED_ID   = 3'd0,
    CFG_SELF_ID   = 3'd1,
    CFG_SUCC_ID   = 3'd2,
    CFG_SELF_IP   = 3'd3,
    CFG_SELF_PORT = 3'd4,
    CFG_SUCC_IP   = 3'd5,
    CFG_SUCC_PORT = 3'd6,
    CFG_VALIDITY  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  // one cache line as stored in the RAM
  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] pred;
    logic [15:0] peer_id;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
  } entry_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] ip;
    logic [15:0] port;
  } peer_t;

  // peer with predecessor prev owns key when its ring distance is shorter, or when prev equals owner
  function automatic logic owns(input logic [15:0] prev, input logic [15:0] owner,
                                input logic [15:0] key);
    logic [15:0] d_prev;
    logic [15:0] d_owner;
    d_prev  = prev - key;
    d_owner = owner - key;
    return (prev == owner) || (d_owner < d_prev);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dhtrc_ram.sv
`default_nettype none
module dhtrc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  wire logic [Width-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic      [Width-1:0]                     rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dht_ring_responsibility_cache.sv
`default_nettype none
// Ring-ownership router with a timed peer cache for one node of a 16-bit DHT.
// Channels:
//   s_axis : one request per beat; tuser = req_type (lookup, reply, local
//            query, invalid), tdata = key, peer id/ip/port and current time.
//   m_axis : exactly one result per request; tuser = action, tdata = dest
//            address, hash field and the peer carried or resolved.
//   cfg    : register writes (index 0..7), always ready; write only while
//            no request is in flight.
// Sequencing: one request at a time. A lookup, reply or query sweeps
// the cache RAM once, one entry per cycle through the single read port;
// a reply then writes its line back before the result is loaded. An
// invalid request skips the sweep. A new request is accepted once the
// previous result has been loaded into the output register.
// The result sits in an output register; the next request is accepted while
// it waits, and that request's result holds in the sequencer until the
// register drains, so a stalled receiver stalls the block without loss.
// Reset: synchronous; clears valid bits of all cache lines (no RAM sweep
// needed), config registers to 0 and validity window to 2000 ms.
module dht_ring_responsibility_cache #(
  parameter int CACHE_ENTRIES = dhtrc_pkg::CacheEntriesDflt
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // request stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,  // key_id, peer_id, peer_ip, peer_port, now_ms
  input  wire logic [1:0]   s_axis_tuser,  // req_type
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata,  // dest_ip, dest_port, msg_hash,
                                           // res_peer_id, res_peer_ip, res_peer_port
  output logic      [2:0]   m_axis_tuser,  // action
  // configuration writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  import dhtrc_pkg::*;

  localparam int IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CntW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(CACHE_ENTRIES);

  // config registers
  logic [15:0] pred_id, self_id, succ_id, self_port, succ_port, validity_ms;
  logic [31:0] self_ip, succ_ip;

  // latched request
  logic [1:0]  req_type;
  logic [15:0] key_id;
  peer_t       peer;
  logic [31:0] now_ms;

  state_t state, state_next;

  // scan control
  logic [CntW-1:0] iss_cnt;      // next entry to read
  logic            rd_pend;      // read data returns this cycle
  logic [IdxW-1:0] rd_idx;
  logic            scan_done;

  // scan results
  logic            hit_found;
  peer_t           hit_peer;
  logic            match_found, free_found;
  logic [IdxW-1:0] match_idx, free_idx, evict_idx;
  logic [31:0]     oldest_age;

  logic [CACHE_ENTRIES-1:0] entry_valid;

  // RAM
  logic            ram_re, ram_we;
  logic [IdxW-1:0] wr_slot;
  entry_t          rd_entry, wr_entry;

  // control
  logic in_acc, out_free, load_out;

  // result assembly
  logic        self_hit, succ_hit, resolved;
  peer_t       who;
  action_t     kind, res_action;
  logic [31:0] res_dest_ip;
  logic [15:0] res_dest_port, res_hash;
  peer_t       res_peer;

  // per-entry evaluation
  logic [31:0] age;
  logic        ent_v, ent_fresh, ent_owns, ent_match;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign scan_done = (iss_cnt == LastCnt) && !rd_pend;

  dhtrc_ram #(
    .Width($bits(entry_t)),
    .Depth(CACHE_ENTRIES)
  ) u_cache_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_slot),
    .wdata(wr_entry),
    .re   (ram_re),
    .raddr(iss_cnt[IdxW-1:0]),
    .rdata(rd_entry)
  );

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      pred_id     <= '0;
      self_id     <= '0;
      succ_id     <= '0;
      self_ip     <= '0;
      self_port   <= '0;
      succ_ip     <= '0;
      succ_port   <= '0;
      validity_ms <= ValidityReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRED_ID:   pred_id     <= cfg_data[15:0];
        CFG_SELF_ID:   self_id     <= cfg_data[15:0];
        CFG_SUCC_ID:   succ_id     <= cfg_data[15:0];
        CFG_SELF_IP:   self_ip     <= cfg_data;
        CFG_SELF_PORT: self_port   <= cfg_data[15:0];
        CFG_SUCC_IP:   succ_ip     <= cfg_data;
        CFG_SUCC_PORT: succ_port   <= cfg_data[15:0];
        CFG_VALIDITY:  validity_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (s_axis_tuser == REQ_INVALID) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = (req_type == REQ_REPLY) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    ram_re        = (state == ST_SCAN) && (iss_cnt < LastCnt);
    ram_we        = (state == ST_WRITE);
    load_out      = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ------------------------------------------------------ per-entry check
  always_comb begin
    ent_v     = entry_valid[rd_idx];
    age       = now_ms - rd_entry.stamp;
    ent_fresh = age < {16'd0, validity_ms};
    ent_owns  = owns(rd_entry.pred, rd_entry.peer_id, key_id);
    ent_match = (rd_entry.peer_id == peer.id) && (rd_entry.peer_ip == peer.ip) &&
                (rd_entry.peer_port == peer.port);
  end

  // request latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend     <= 1'b0;
      iss_cnt     <= '0;
      hit_found   <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (in_acc) begin
      rd_pend     <= 1'b0;
      iss_cnt     <= '0;
      hit_found   <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      rd_pend <= ram_re;
      if (ram_re) begin
        iss_cnt <= iss_cnt + 1'b1;
      end
      if (rd_pend) begin
        // first valid, fresh, owning entry wins
        if (!hit_found && ent_v && ent_owns && ent_fresh) begin
          hit_found <= 1'b1;
        end
        if (!match_found && ent_v && ent_match) begin
          match_found <= 1'b1;
        end
        if (!free_found && !ent_v) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_type  <= s_axis_tuser;
      key_id    <= s_axis_tdata[15:0];
      peer.id   <= s_axis_tdata[31:16];
      peer.ip   <= s_axis_tdata[63:32];
      peer.port <= s_axis_tdata[79:64];
      now_ms    <= s_axis_tdata[111:80];
    end
    if (ram_re) begin
      rd_idx <= iss_cnt[IdxW-1:0];
    end
    if (rd_pend) begin
      if (!hit_found && ent_v && ent_owns && ent_fresh) begin
        hit_peer <= '{id: rd_entry.peer_id, ip: rd_entry.peer_ip, port: rd_entry.peer_port};
      end
      if (!match_found && ent_v && ent_match) begin
        match_idx <= rd_idx;
      end
      if (!free_found && !ent_v) begin
        free_idx <= rd_idx;
      end
      // eviction candidate: greatest age, first one on ties
      if (rd_idx == '0 || age > oldest_age) begin
        oldest_age <= age;
        evict_idx  <= rd_idx;
      end
    end
  end

  // ---------------------------------------------------------- write-back
  always_comb begin
    if (match_found) begin
      wr_slot = match_idx;
    end else if (free_found) begin
      wr_slot = free_idx;
    end else begin
      wr_slot = evict_idx;
    end
    // a refresh rewrites the same id/ip/port, so one full-line write covers both
    wr_entry = '{stamp: now_ms, pred: key_id, peer_id: peer.id, peer_ip: peer.ip,
                 peer_port: peer.port};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[wr_slot] <= 1'b1;
    end
  end

  // ------------------------------------------------------ result assembly
  always_comb begin
    self_hit = owns(pred_id, self_id, key_id);
    succ_hit = owns(self_id, succ_id, key_id);
    if (self_hit) begin
      kind = ACT_SELF;
      who  = '{id: self_id, ip: self_ip, port: self_port};
    end else if (succ_hit) begin
      kind = ACT_SUCC;
      who  = '{id: succ_id, ip: succ_ip, port: succ_port};
    end else if (hit_found) begin
      kind = ACT_CACHE_HIT;
      who  = hit_peer;
    end else begin
      kind = ACT_UNKNOWN;
      who  = '0;
    end
    resolved = (kind != ACT_UNKNOWN);

    res_action    = ACT_INVALID;
    res_dest_ip   = '0;
    res_dest_port = '0;
    res_hash      = '0;
    res_peer      = '0;
    case (req_type)
      REQ_LOOKUP: begin
        if (resolved && who.id == succ_id && who.ip == succ_ip && who.port == succ_port) begin
          res_action    = ACT_REPLY;
          res_dest_ip   = peer.ip;
          res_dest_port = peer.port;
          res_hash      = self_id;
          res_peer      = '{id: succ_id, ip: succ_ip, port: succ_port};
        end else begin
          res_action    = ACT_FORWARD;
          res_dest_ip   = succ_ip;
          res_dest_port = succ_port;
          res_hash      = key_id;
          res_peer      = peer;
        end
      end
      REQ_REPLY: begin
        res_action = ACT_CACHE_UPD;
        res_peer   = peer;
      end
      REQ_QUERY: begin
        res_action = kind;
        res_peer   = who;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tuser <= res_action;
      m_axis_tdata <= {res_peer.port, res_peer.ip, res_peer.id, res_hash,
                       res_dest_port, res_dest_ip};
    end
  end

`ifndef SYNTHESIS
  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten while stalled");

  // the line just written is marked valid
  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> entry_valid[$past(wr_slot)])
    else $error("written cache line not valid");

  // lines are only ever added, never dropped, outside reset
  a_valid_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(entry_valid) >= $past($countones(entry_valid)))
    else $error("cache line lost its valid bit");

  // the sweep never reads past the last line
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (iss_cnt < LastCnt) && (state == ST_SCAN))
    else $error("cache read beyond last line");
`endif

endmodule
`default_nettype wire
